>>> design/ssm_pkg.sv
// shared types and constants for the shear sort matrix block
// depends on nothing
package ssm_pkg;
   localparam int MAX_SIDE   = 16;
   localparam int VALUE_BITS = 16;
   localparam int CELLS      = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_BITS  = $clog2(CELLS);
   localparam int SIDE_BITS  = $clog2(MAX_SIDE + 1);
   localparam int POS_BITS   = $clog2(MAX_SIDE);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [VALUE_BITS-1:0] value;
      logic [7:0]            index;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] sorted_value;
      logic                  out_of_range;
   } rsp_type;
endpackage

>>> design/shear_sort_matrix.sv
// shear sort matrix top level: load, odd-even transposition sort in one ram, snake reads
// depends on ssm_pkg
//
//  channel  | ports                         | beat
//  ---------+-------------------------------+---------------------------
//  request  | req_valid req_ready req_data  | load element or read index
//  response | rsp_valid rsp_ready rsp_data  | one per read
//  config   | csr_we csr_wdata              | side length
//
// a load is written to the ram when accepted; a read passes through ST_READ, which registers
// the response, and further requests wait until the response beat is taken
// the last load runs odd-even transposition passes with one comparator on the ram:
// each compare-exchange steps through ST_RD (read two), ST_CMP (compare, write a) and
// ST_CMP2 (write b); reset is synchronous and clears control state only
// requests are stalled while sorting or while a response waits
module shear_sort_matrix (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ssm_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ssm_pkg::rsp_type      rsp_data,
   input  logic                  csr_we,
   input  logic [4:0]            csr_wdata
);
   import ssm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0, ST_RD = 3'd1, ST_CMP = 3'd2,
                          ST_READ = 3'd3, ST_CMP2 = 3'd4;

   logic [VALUE_BITS-1:0] mem [CELLS];
   logic [VALUE_BITS-1:0] rd_a_ff, rd_b_ff;
   logic [ADDR_BITS-1:0]  addr_a, addr_b;

   logic [4:0]            side_ff;
   logic [2:0]            state_ff, state_in;
   logic [ADDR_BITS:0]    load_ff, load_in;
   logic [3:0]            phase_ff, phase_in;
   logic                  colmode_ff, colmode_in;   // 0 rows, 1 columns
   logic                  final_ff, final_in;       // closing row phase
   logic [POS_BITS-1:0]   line_ff, line_in;
   logic [POS_BITS:0]     pass_ff, pass_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  oor_ff, oor_in;
   logic [ADDR_BITS-1:0]  raddr_ff, raddr_in;

   logic [SIDE_BITS-1:0]  s;
   logic [ADDR_BITS:0]    n;
   logic [3:0]            phases;
   logic [3:0]            b;
   logic                  desc, swap;
   logic                  we;
   logic [ADDR_BITS-1:0]  wa;
   logic [VALUE_BITS-1:0] wd;
   logic                  accept;
   logic [POS_BITS-1:0]   r_row, r_col;
   logic                  odd_next;
   logic [ADDR_BITS:0]    lin_a;

   always_comb begin
      if (side_ff == 5'd0) s = SIDE_BITS'(1);
      else if (side_ff > 5'(MAX_SIDE)) s = SIDE_BITS'(MAX_SIDE);
      else s = SIDE_BITS'(side_ff);
      n = (ADDR_BITS+1)'(s) * (ADDR_BITS+1)'(s);
      b = 4'd0;
      for (int k = 1; k <= ADDR_BITS; k++) begin
         if ((ADDR_BITS+1)'(1 << (k-1)) < n) b = 4'(k);
      end
      phases = 4'((b + 4'd2) >> 1);
   end

   // position pair (pos, pos+1) along current line
   always_comb begin
      if (colmode_ff) begin
         addr_a = ADDR_BITS'(pos_ff) * ADDR_BITS'(s) + ADDR_BITS'(line_ff);
         addr_b = addr_a + ADDR_BITS'(s);
      end else begin
         addr_a = ADDR_BITS'(line_ff) * ADDR_BITS'(s) + ADDR_BITS'(pos_ff);
         addr_b = addr_a + ADDR_BITS'(1);
      end
      desc = !colmode_ff && line_ff[0];
      swap = desc ? (rd_a_ff < rd_b_ff) : (rd_a_ff > rd_b_ff);
      odd_next = ~pass_ff[0];
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.sorted_value = oor_ff ? '0 : rd_a_ff;
   assign rsp_data.out_of_range = oor_ff;

   // read address for snake index
   always_comb begin
      r_row = '0;
      r_col = '0;
      for (int k = 0; k < MAX_SIDE; k++) begin
         if ((ADDR_BITS+1)'(k) * (ADDR_BITS+1)'(s) <= (ADDR_BITS+1)'(req_data.index)
             && k < int'(s)) begin
            r_row = POS_BITS'(k);
         end
      end
      lin_a = (ADDR_BITS+1)'(req_data.index)
              - (ADDR_BITS+1)'(r_row) * (ADDR_BITS+1)'(s);
      r_col = POS_BITS'(lin_a);
      if (r_row[0]) r_col = POS_BITS'(s - SIDE_BITS'(1)) - r_col;
   end

   always_comb begin
      state_in     = state_ff;
      load_in      = load_ff;
      phase_in     = phase_ff;
      colmode_in   = colmode_ff;
      final_in     = final_ff;
      line_in      = line_ff;
      pass_in      = pass_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      oor_in       = oor_ff;
      raddr_in     = raddr_ff;
      we = 1'b0;
      wa = addr_a;
      wd = rd_a_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_LOAD) begin
                  if (load_ff < n) begin
                     we = 1'b1;
                     wa = ADDR_BITS'(load_ff);
                     wd = req_data.value;
                     load_in = load_ff + 1'b1;
                  end
                  if (req_data.last) begin
                     load_in = '0;
                     phase_in = '0;
                     colmode_in = 1'b0;
                     final_in = 1'b0;
                     line_in = '0;
                     pass_in = '0;
                     pos_in = '0;
                     state_in = (s > SIDE_BITS'(1)) ? ST_RD : ST_IDLE;
                  end
               end else begin
                  oor_in = (ADDR_BITS+1)'(req_data.index) >= n;
                  raddr_in = ADDR_BITS'(r_row) * ADDR_BITS'(s) + ADDR_BITS'(r_col);
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RD: state_in = ST_CMP;
         ST_CMP: state_in = ST_CMP2;
         ST_CMP2: begin
            // second half of the exchange writes b's slot
            state_in = ST_RD;
            if ((POS_BITS+1)'(pos_ff) + 2 < (POS_BITS+1)'(s) - 1) begin
               pos_in = pos_ff + POS_BITS'(2);
            end else if (pass_ff + 1'b1 < (POS_BITS+1)'(s)) begin
               pass_in = pass_ff + 1'b1;
               pos_in = POS_BITS'(odd_next);
               if (POS_BITS'(odd_next) + 1 >= s) pos_in = '0;
            end else if ((SIDE_BITS)'(line_ff) + 1 < s) begin
               line_in = line_ff + 1'b1;
               pass_in = '0;
               pos_in = '0;
            end else begin
               line_in = '0;
               pass_in = '0;
               pos_in = '0;
               if (final_ff) begin
                  state_in = ST_IDLE;
                  final_in = 1'b0;
               end else if (!colmode_ff) begin
                  colmode_in = 1'b1;
               end else begin
                  colmode_in = 1'b0;
                  phase_in = phase_ff + 1'b1;
                  if (phase_ff + 1'b1 >= phases) begin
                     final_in = 1'b1;
                     phase_in = '0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ram: one write port, registered reads
   always_ff @(posedge clock) begin
      if (state_ff == ST_CMP && swap) mem[addr_a] <= rd_b_ff;
      else if (state_ff == ST_CMP2 && swap) mem[addr_b] <= rd_a_ff;
      else if (we) mem[wa] <= wd;
      if (state_ff == ST_READ) rd_a_ff <= mem[raddr_ff];
      else if (state_ff == ST_RD) begin
         rd_a_ff <= mem[addr_a];
         rd_b_ff <= mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= 5'd16;
         state_ff     <= ST_IDLE;
         load_ff      <= '0;
         phase_ff     <= '0;
         colmode_ff   <= 1'b0;
         final_ff     <= 1'b0;
         line_ff      <= '0;
         pass_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) side_ff <= csr_wdata;
         state_ff     <= state_in;
         load_ff      <= load_in;
         phase_ff     <= phase_in;
         colmode_ff   <= colmode_in;
         final_ff     <= final_in;
         line_ff      <= line_in;
         pass_ff      <= pass_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      oor_ff   <= oor_in;
      raddr_ff <= raddr_in;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("accept while busy");
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid) else $error("read lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_ff <= (ADDR_BITS+1)'(CELLS)) else $error("load count overflow");
endmodule
